[hw/rtl/cbt_pkg.sv]
// Package for the cubic Bezier tessellator: widths, request and status codes,
// controller states, control structs and the Bernstein weight table.
// No dependencies.
package cbt_pkg;

  localparam int STEPS    = 100;
  localparam int STEP_W   = 7;
  localparam int TAB_DEPTH = 1 << STEP_W;
  localparam int PT_W     = 16;
  localparam int WEIGHT_W = 17;
  localparam int PROD_W   = PT_W + WEIGHT_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int OUT_W    = 24;
  localparam int HELD_W   = 3;
  localparam int TAP_W    = 2;
  localparam int TAPS     = 4;

  localparam longint Q_ONE       = 64'd65536;
  localparam longint STEPS_CUBED = longint'(STEPS) * STEPS * STEPS;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_EMIT  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_EMITTED = 2'd0,
    ST_LOADED  = 2'd1,
    ST_REFUSED = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_WRITE
  } cbt_state_t;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    logic             acc_en;
    logic [TAP_W-1:0] tap;
    logic             commit;
  } cbt_cmd_t;

  typedef struct packed {
    logic              emit_go;
    logic              seg_ready;
    logic [HELD_W-1:0] held;
  } cbt_stat_t;

  typedef logic [TAPS-1:0][WEIGHT_W-1:0] weight_row_t;
  typedef weight_row_t [TAB_DEPTH-1:0] weight_tab_t;

  function automatic longint scale_weight(input longint num);
    return (num * Q_ONE + STEPS_CUBED / 2) / STEPS_CUBED;
  endfunction

  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    longint      k;
    longint      u;
    for (int kk = 0; kk < TAB_DEPTH; kk++) begin
      k = longint'(kk);
      u = longint'(STEPS) - k;
      if (kk <= STEPS) begin
        tab[kk][0] = WEIGHT_W'(scale_weight(u * u * u));
        tab[kk][1] = WEIGHT_W'(scale_weight(3 * k * u * u));
        tab[kk][2] = WEIGHT_W'(scale_weight(3 * k * k * u));
        tab[kk][3] = WEIGHT_W'(scale_weight(k * k * k));
      end else begin
        tab[kk] = '0;
      end
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHTS = build_weights();

endpackage

[hw/rtl/cbt_ifs.sv]
// Channel interfaces of the cubic Bezier tessellator: request and result.
// Depends on cbt_pkg for field widths.
interface cbt_req_if import cbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic signed [PT_W-1:0] point_x;
  logic signed [PT_W-1:0] point_y;

  modport source (output valid, req_type, point_x, point_y, input ready);
  modport sink (input valid, req_type, point_x, point_y, output ready);
endinterface

interface cbt_res_if import cbt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] curve_x;
  logic signed [OUT_W-1:0] curve_y;
  logic [1:0]              status;
  logic                    last_of_segment;

  modport source (output valid, curve_x, curve_y, status, last_of_segment, input ready);
  modport sink (input valid, curve_x, curve_y, status, last_of_segment, output ready);
endinterface

[hw/rtl/cbt_ctrl.sv]
// Controller of the cubic Bezier tessellator: sequences capture, the four
// multiply-accumulate taps and the result write. Depends on cbt_pkg.
module cbt_ctrl import cbt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  input  cbt_stat_t stat,
  output logic      in_ready,
  output logic      out_valid,
  output cbt_cmd_t  cmd
);

  cbt_state_t       state;
  cbt_state_t       state_next;
  logic [TAP_W-1:0] tap;
  logic             accept;
  logic             slot_free;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else if (state == S_MUL) begin
      tap <= tap + TAP_W'(1);
    end else begin
      tap <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = stat.emit_go ? S_MUL : S_WRITE;
        end
      end
      S_MUL: begin
        if (tap == TAP_W'(TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.acc_en  = 1'b0;
    cmd.tap     = tap;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (tap != '0);
      end
      S_DRAIN: begin
        cmd.acc_en = 1'b1;
      end
      S_WRITE: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/cbt_datapath.sv]
// Datapath of the cubic Bezier tessellator: control point window, counters,
// shared multiply-accumulate pair and result register. Depends on cbt_pkg.
module cbt_datapath import cbt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cbt_cmd_t                cmd,
  input  logic [1:0]              req_type,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  output cbt_stat_t               stat,
  output logic signed [OUT_W-1:0] curve_x,
  output logic signed [OUT_W-1:0] curve_y,
  output logic [1:0]              status,
  output logic                    last_of_segment
);

  logic signed [PT_W-1:0]   win_x [TAPS];
  logic signed [PT_W-1:0]   win_y [TAPS];
  logic [HELD_W-1:0]        held;
  logic [STEP_W-1:0]        step;
  logic                     seg_ready;
  logic [1:0]               req_q;
  logic signed [PT_W-1:0]   pt_x_q;
  logic signed [PT_W-1:0]   pt_y_q;
  weight_row_t              wrow;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [ACC_W-1:0]  acc_x;
  logic signed [ACC_W-1:0]  acc_y;
  logic signed [OUT_W-1:0]  res_x;
  logic signed [OUT_W-1:0]  res_y;

  function automatic logic signed [OUT_W-1:0] to_q16_8(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic [ACC_W-9:0]        q;
    logic [OUT_W-1:0]        r;
    v = acc + ACC_W'(128);
    q = v[ACC_W-1:8];
    if (!q[ACC_W-9] && (|q[ACC_W-9:OUT_W-1])) begin
      r = {1'b0, {(OUT_W - 1){1'b1}}};
    end else if (q[ACC_W-9] && !(&q[ACC_W-9:OUT_W-1])) begin
      r = {1'b1, {(OUT_W - 1){1'b0}}};
    end else begin
      r = q[OUT_W-1:0];
    end
    return $signed(r);
  endfunction

  assign stat.emit_go   = (req_type == REQ_EMIT) && seg_ready;
  assign stat.seg_ready = seg_ready;
  assign stat.held      = held;

  assign res_x = to_q16_8(acc_x);
  assign res_y = to_q16_8(acc_y);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      pt_x_q <= point_x;
      pt_y_q <= point_y;
      wrow   <= WEIGHTS[step];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x <= win_x[cmd.tap] * $signed({1'b0, wrow[cmd.tap]});
      prod_y <= win_y[cmd.tap] * $signed({1'b0, wrow[cmd.tap]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_x <= '0;
      acc_y <= '0;
    end else if (cmd.acc_en) begin
      acc_x <= acc_x + {{(ACC_W - PROD_W){prod_x[PROD_W-1]}}, prod_x};
      acc_y <= acc_y + {{(ACC_W - PROD_W){prod_y[PROD_W-1]}}, prod_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      step      <= '0;
      seg_ready <= 1'b0;
    end else if (cmd.commit) begin
      curve_x         <= '0;
      curve_y         <= '0;
      status          <= ST_REFUSED;
      last_of_segment <= 1'b0;
      unique case (req_q)
        REQ_LOAD: begin
          if (!seg_ready && (held < HELD_W'(TAPS))) begin
            win_x[held[TAP_W-1:0]] <= pt_x_q;
            win_y[held[TAP_W-1:0]] <= pt_y_q;
            held   <= held + HELD_W'(1);
            status <= ST_LOADED;
            if (held == HELD_W'(TAPS - 1)) begin
              seg_ready <= 1'b1;
              step      <= '0;
            end
          end
        end
        REQ_EMIT: begin
          if (seg_ready) begin
            curve_x <= res_x;
            curve_y <= res_y;
            status  <= ST_EMITTED;
            if (step >= STEP_W'(STEPS)) begin
              last_of_segment <= 1'b1;
              win_x[0]        <= win_x[TAPS-1];
              win_y[0]        <= win_y[TAPS-1];
              held            <= HELD_W'(1);
              seg_ready       <= 1'b0;
              step            <= '0;
            end else begin
              step <= step + STEP_W'(1);
            end
          end
        end
        REQ_CLEAR: begin
          held      <= '0;
          step      <= '0;
          seg_ready <= 1'b0;
          status    <= ST_CLEARED;
        end
        default: begin
          status <= ST_REFUSED;
        end
      endcase
    end
  end

endmodule

[hw/rtl/cubic_bezier_tessellator.sv]
// Top level of the cubic Bezier tessellator: controller, datapath and the
// request and result channels. Depends on cbt_pkg, cbt_ifs, cbt_ctrl and
// cbt_datapath.
//
//   channel  direction  payload
//   req      in         req_type, point_x, point_y
//   res      out        curve_x, curve_y, status, last_of_segment
//
// After its transfer, an emit request on a ready segment runs the four taps through
// the shared x and y multipliers, drains the accumulators, writes the rounded
// result and returns to idle, where the next request is taken. Other requests,
// and an emit with no ready segment, go straight to the write and back to idle.
// Synchronous reset empties the window, clears the counters and drops res valid.
// A result that waits on res stalls only the next write; requests are still
// taken and worked up to that point.
module cubic_bezier_tessellator import cbt_pkg::*; (
  input logic      clk,
  input logic      rst,
  cbt_req_if.sink   req,
  cbt_res_if.source res
);

  cbt_cmd_t  cmd;
  cbt_stat_t stat;

  cbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .cmd       (cmd)
  );

  cbt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req_type        (req.req_type),
    .point_x         (req.point_x),
    .point_y         (req.point_y),
    .stat            (stat),
    .curve_x         (res.curve_x),
    .curve_y         (res.curve_y),
    .status          (res.status),
    .last_of_segment (res.last_of_segment)
  );

`ifndef NO_ASSERTIONS
  a_commit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(res.valid && !res.ready))
    else $error("result written over a pending transfer");

  a_seg_ready_full: assert property (@(posedge clk) disable iff (rst)
    stat.seg_ready == (stat.held == HELD_W'(TAPS)))
    else $error("segment ready disagrees with window fill");

  a_commit_then_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (req.ready && res.valid))
    else $error("no result or no return to idle after a write");
`endif

endmodule
